@@ hw/rtl/oit_pkg.sv @@
// Shared constants, codes and types for the two-channel interval timer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package oit_pkg;

	localparam int CHANNELS = 2;
	localparam int DATA_W   = 32;
	localparam int CMD_W    = 3;
	localparam int ADDR_W   = 4;
	localparam int SEL_W    = 3;
	localparam int IRQ_W    = 2;
	localparam int RS_W     = 2;
	localparam int PADDR_W  = 3;

	// Commands carried on the request channel
	localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_RD_BYTE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RD_WORD = 3'd2;
	localparam logic [CMD_W-1:0] CMD_WR_BYTE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_WR_WORD = 3'd4;

	// Register select codes (low address bits)
	localparam logic [SEL_W-1:0] SEL_COMPARE = 3'd0;
	localparam logic [SEL_W-1:0] SEL_COUNT   = 3'd1;
	localparam logic [SEL_W-1:0] SEL_STATUS  = 3'd2;
	localparam logic [SEL_W-1:0] SEL_START   = 3'd3;
	localparam logic [SEL_W-1:0] SEL_STOP    = 3'd4;
	localparam logic [SEL_W-1:0] SEL_CONTROL = 3'd5;

	// Channel run states
	localparam logic [RS_W-1:0] RS_STOPPED = 2'd0;
	localparam logic [RS_W-1:0] RS_READY   = 2'd1;
	localparam logic [RS_W-1:0] RS_RUNNING = 2'd2;

	// Configuration register map (index is paddr[2])
	localparam logic REG_PRESCALE = 1'b0;

	localparam logic [DATA_W-1:0] DIVIDE_RESET = 32'd50000;

	// Operation handed to one channel for the current beat
	typedef struct packed {
		logic              update;
		logic              wr_control;
		logic              wr_start;
		logic              wr_stop;
		logic              wr_compare;
		logic [DATA_W-1:0] data;
		logic [DATA_W-1:0] seen;
	} oit_chan_op_t;

	// What a channel reports back
	typedef struct packed {
		logic              running;
		logic              irq;
		logic [DATA_W-1:0] count;
	} oit_chan_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/oit_req_if.sv @@
// Request channel: valid/ready handshake carrying one timer command beat.
// Depends on oit_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface oit_req_if
	import oit_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [ADDR_W-1:0] register_address;
	logic [DATA_W-1:0] write_data;

	modport source (output valid, output command, output register_address,
		output write_data, input ready);
	modport sink (input valid, input command, input register_address,
		input write_data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/oit_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one result beat.
// Depends on oit_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface oit_rsp_if
	import oit_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic [IRQ_W-1:0]  irq_flags;

	modport source (output valid, output read_data, output irq_flags, input ready);
	modport sink (input valid, input read_data, input irq_flags, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/oit_prescaler.sv @@
// Shared prescaler and update counter of the interval timer.
// Depends on oit_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oit_prescaler
	import oit_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              tick,
	input  wire logic [DATA_W-1:0] divide,
	output logic                   update,
	output logic [DATA_W-1:0]      seen
);

	logic [DATA_W-1:0] presc_q;
	logic [DATA_W-1:0] seen_q;
	logic [DATA_W-1:0] div_eff;
	logic [DATA_W:0]   next_wide;
	logic              wrap;

	// A zero divider acts as one
	assign div_eff   = (divide == '0) ? DATA_W'(1) : divide;
	assign next_wide = {1'b0, presc_q} + (DATA_W+1)'(1);
	assign wrap      = next_wide[DATA_W] || (next_wide[DATA_W-1:0] >= div_eff);
	assign update    = tick && (presc_q == '0);
	assign seen      = seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presc_q <= '0;
			seen_q  <= '0;
		end else if (tick) begin
			presc_q <= wrap ? '0 : next_wide[DATA_W-1:0];
			if (update) begin
				seen_q <= seen_q + DATA_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/oit_channel.sv @@
// One compare-match timer channel: run state, count, compare and enable.
// Depends on oit_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oit_channel
	import oit_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire oit_chan_op_t op,
	output oit_chan_stat_t stat
);

	logic [RS_W-1:0]   rs_q, rs_n;
	logic [DATA_W-1:0] cnt_q, cnt_n;
	logic [DATA_W-1:0] cmp_q, cmp_n;
	logic              en_q, en_n;
	logic              started_q, started_n;
	logic              irq;

	always_comb begin
		rs_n      = rs_q;
		cnt_n     = cnt_q;
		cmp_n     = cmp_q;
		en_n      = en_q;
		started_n = started_q;
		irq       = 1'b0;
		if (op.update) begin
			unique case (rs_q)
				RS_READY: begin
					rs_n      = RS_RUNNING;
					started_n = 1'b1;
					cnt_n     = '0;
				end
				RS_RUNNING: begin
					cnt_n = cnt_q + DATA_W'(1);
				end
				default: begin
					// never started: track the update count minus one
					if (!started_q) begin
						cnt_n = op.seen;
					end
				end
			endcase
			// match re-arms even a stopped channel
			if (en_q && (cnt_n == cmp_q)) begin
				rs_n = RS_READY;
				irq  = 1'b1;
			end
		end
		if (op.wr_control) begin
			en_n = ~op.data[0];
		end
		if (op.wr_start && op.data[0]) begin
			rs_n = RS_READY;
		end
		if (op.wr_stop && op.data[0]) begin
			rs_n = RS_STOPPED;
		end
		if (op.wr_compare) begin
			cmp_n = op.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q      <= RS_STOPPED;
			cnt_q     <= '0;
			cmp_q     <= '0;
			en_q      <= 1'b0;
			started_q <= 1'b0;
		end else begin
			rs_q      <= rs_n;
			cnt_q     <= cnt_n;
			cmp_q     <= cmp_n;
			en_q      <= en_n;
			started_q <= started_n;
		end
	end

	assign stat.running = (rs_q != RS_STOPPED);
	assign stat.irq     = irq;
	assign stat.count   = cnt_q;

endmodule

`default_nettype wire

@@ hw/rtl/os_interval_timer_channels.sv @@
// Path: input register, then response register. Throughput: one request beat
// per cycle while no response stalls; the two registers are parted, so a new
// beat enters the empty input register while a result waits to be taken.
// Reset: arst_n clears prescaler, update count and all channel state at once;
// the divider returns to 50000. No clearing pass.
// Depends on oit_pkg, oit_req_if, oit_rsp_if, oit_prescaler and oit_channel.
`timescale 1ns / 1ps
`default_nettype none

module os_interval_timer_channels
	import oit_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	oit_req_if.sink                 req,
	oit_rsp_if.source               rsp,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready
);

	// ------------------------------------------------------------------
	// Configuration: single divider register at byte address 0
	// ------------------------------------------------------------------
	logic [DATA_W-1:0] divide_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PRESCALE);
	assign prdata = (paddr[2] == REG_PRESCALE) ? divide_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divide_q <= DIVIDE_RESET;
		end else if (cfg_wr) begin
			divide_q <= pwdata;
		end
	end

	// ------------------------------------------------------------------
	// Input register. Hold the beat while the response register is full
	// and not being drained; otherwise take a new one every cycle.
	// ------------------------------------------------------------------
	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [DATA_W-1:0] data_s1;
	logic              rsp_valid_q;
	logic              advance;
	logic              proc;

	assign advance   = !rsp_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || advance;
	assign proc      = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			cmd_s1  <= req.command;
			addr_s1 <= req.register_address;
			data_s1 <= req.write_data;
		end
	end

	// ------------------------------------------------------------------
	// Decode the held beat
	// ------------------------------------------------------------------
	logic              ch_s1;
	logic [SEL_W-1:0]  sel_s1;
	logic              is_tick;
	logic              upd;
	logic [DATA_W-1:0] seen;

	assign ch_s1   = addr_s1[ADDR_W-1];
	assign sel_s1  = addr_s1[SEL_W-1:0];
	assign is_tick = proc && (cmd_s1 == CMD_TICK);

	oit_prescaler u_prescaler (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (is_tick),
		.divide (divide_q),
		.update (upd),
		.seen   (seen)
	);

	// ------------------------------------------------------------------
	// Channels: each sees the shared update plus any access aimed at it
	// ------------------------------------------------------------------
	oit_chan_op_t   op   [CHANNELS];
	oit_chan_stat_t stat [CHANNELS];
	logic           hit  [CHANNELS];

	for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
		// channels beyond the address reach only ever see the shared update
		assign hit[c] = proc && ({31'b0, ch_s1} == 32'(c));

		assign op[c].update     = upd;
		assign op[c].wr_control = hit[c] && (cmd_s1 == CMD_WR_BYTE) && (sel_s1 == SEL_CONTROL);
		assign op[c].wr_start   = hit[c] && (cmd_s1 == CMD_WR_BYTE) && (sel_s1 == SEL_START);
		assign op[c].wr_stop    = hit[c] && (cmd_s1 == CMD_WR_BYTE) && (sel_s1 == SEL_STOP);
		assign op[c].wr_compare = hit[c] && (cmd_s1 == CMD_WR_WORD) && (sel_s1 == SEL_COMPARE);
		assign op[c].data       = data_s1;
		assign op[c].seen       = seen;

		oit_channel u_channel (
			.clk    (clk),
			.arst_n (arst_n),
			.op     (op[c]),
			.stat   (stat[c])
		);
	end

	// ------------------------------------------------------------------
	// Result: read mux and interrupt flags
	// ------------------------------------------------------------------
	logic [DATA_W-1:0] rd_next;
	logic [IRQ_W-1:0]  irq_next;

	always_comb begin
		rd_next = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (hit[c] && (cmd_s1 == CMD_RD_BYTE) && (sel_s1 == SEL_STATUS)) begin
				rd_next = rd_next | DATA_W'(stat[c].running);
			end
			if (hit[c] && (cmd_s1 == CMD_RD_WORD) && (sel_s1 == SEL_COUNT)) begin
				rd_next = rd_next | stat[c].count;
			end
		end
	end

	// only the low channels have a flag bit on the response
	for (genvar i = 0; i < IRQ_W; i++) begin : g_irq
		if (i < CHANNELS) begin : g_used
			assign irq_next[i] = stat[i].irq;
		end else begin : g_none
			assign irq_next[i] = 1'b0;
		end
	end

	logic [DATA_W-1:0] rd_q;
	logic [IRQ_W-1:0]  irq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			rd_q  <= rd_next;
			irq_q <= irq_next;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = rd_q;
	assign rsp.irq_flags = irq_q;

`ifndef SYNTHESIS
	// an interrupt only comes out of a prescaler update on a tick
	a_irq_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		proc && (irq_next != '0) |-> is_tick && upd)
		else $error("interrupt raised without a counter update");

	// a tick never returns read data
	a_tick_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		is_tick |-> (rd_next == '0))
		else $error("read data on a tick beat");

	// a stalled input beat stays put
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(cmd_s1) && $stable(addr_s1)
			&& $stable(data_s1))
		else $error("input register changed while stalled");

	// a finished response is only replaced once taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |=> rsp_valid_q && $stable(rd_q) && $stable(irq_q))
		else $error("response register overwritten while stalled");
`endif

endmodule

`default_nettype wire
